// ===== rtl/core/grid_axis_line_generator_defines.svh =====
// Assertion macros shared by the grid axis line generator RTL.
// Each macro expects signals named clk and arst_n in the including scope.
`ifndef GRID_AXIS_LINE_GENERATOR_DEFINES_SVH
`define GRID_AXIS_LINE_GENERATOR_DEFINES_SVH

// Condition implies a consequence in the same cycle.
`define GAL_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition implies a consequence in the next cycle.
`define GAL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/gal_pkg.sv =====
// Shared types and constants for the grid axis line generator.
// Used by gal_ctrl, gal_datapath and grid_axis_line_generator; depends on nothing.
package gal_pkg;

	localparam int CountW         = 4;
	localparam int StepW          = 16;
	localparam int CoordW         = 21;
	localparam int ColorW         = 3;
	localparam int HalfMaxDefault = 14;

	typedef logic [ColorW-1:0] color_t;
	typedef logic signed [CoordW-1:0] coord_t;

	localparam color_t ColorGray  = 3'd0;
	localparam color_t ColorRed   = 3'd1;
	localparam color_t ColorGreen = 3'd2;
	localparam color_t ColorBlue  = 3'd3;
	localparam color_t ColorWhite = 3'd4;

	// Which segment the datapath builds from the current position
	typedef enum logic [3:0] {
		SEG_COL,
		SEG_COL_POS,
		SEG_COL_NEG,
		SEG_ROW,
		SEG_ROW_POS,
		SEG_ROW_NEG,
		SEG_YAXIS,
		SEG_TOP,
		SEG_BOTTOM,
		SEG_LEFT,
		SEG_RIGHT
	} seg_kind_t;

	typedef struct packed {
		logic      load;
		logic      calc;
		logic      pos_col_init;
		logic      pos_row_init;
		logic      pos_adv;
		logic      emit;
		seg_kind_t seg;
	} dp_cmd_t;

	typedef struct packed {
		logic [CountW-1:0] col_count;
		logic [CountW-1:0] row_count;
		logic              out_free;
	} dp_status_t;

endpackage

// ===== rtl/core/gal_datapath.sv =====
// Datapath of the grid axis line generator: request capture, extents,
// running line position and the registered output segment. Depends on gal_pkg.
module gal_datapath #(
	parameter int HALF_MAX = gal_pkg::HalfMaxDefault
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  gal_pkg::dp_cmd_t                 cmd,
	output gal_pkg::dp_status_t              status,
	input  logic [gal_pkg::CountW-1:0]       half_columns,
	input  logic [gal_pkg::CountW-1:0]       rows_per_side,
	input  logic [gal_pkg::StepW-1:0]        step_size,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [gal_pkg::CoordW-1:0] start_x,
	output logic signed [gal_pkg::CoordW-1:0] start_y,
	output logic signed [gal_pkg::CoordW-1:0] start_z,
	output logic signed [gal_pkg::CoordW-1:0] end_x,
	output logic signed [gal_pkg::CoordW-1:0] end_y,
	output logic signed [gal_pkg::CoordW-1:0] end_z,
	output logic [gal_pkg::ColorW-1:0]        color_code,
	output logic                             last_segment
);

	localparam int ProdW = gal_pkg::CountW + gal_pkg::StepW;
	localparam logic [gal_pkg::CountW-1:0] HalfLim = gal_pkg::CountW'(HALF_MAX);

	logic [gal_pkg::CountW-1:0] cols_q;
	logic [gal_pkg::CountW-1:0] rows_q;
	logic [gal_pkg::StepW-1:0]  step_q;
	gal_pkg::coord_t            width_q;
	gal_pkg::coord_t            height_q;
	gal_pkg::coord_t            pos_q;

	logic [ProdW-1:0] width_prod;
	logic [ProdW-1:0] height_prod;
	gal_pkg::coord_t  step_ext;

	gal_pkg::coord_t sx, sy, sz, ex, ey, ez;
	gal_pkg::color_t color;
	logic            last;

	logic            out_valid_q;
	gal_pkg::coord_t sx_q, sy_q, sz_q, ex_q, ey_q, ez_q;
	gal_pkg::color_t color_q;
	logic            last_q;

	assign width_prod  = ProdW'(cols_q) * ProdW'(step_q);
	assign height_prod = ProdW'(rows_q) * ProdW'(step_q);
	assign step_ext    = $signed({{(gal_pkg::CoordW - gal_pkg::StepW){1'b0}}, step_q});

	// Request capture, extents and running position
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cols_q <= (half_columns > HalfLim) ? HalfLim : half_columns;
			rows_q <= (rows_per_side > HalfLim) ? HalfLim : rows_per_side;
			step_q <= step_size;
		end
		if (cmd.calc) begin
			width_q  <= $signed({1'b0, width_prod});
			height_q <= $signed({1'b0, height_prod});
		end
		if (cmd.pos_col_init) begin
			pos_q <= step_ext - width_q;
		end else if (cmd.pos_row_init) begin
			pos_q <= step_ext - height_q;
		end else if (cmd.pos_adv) begin
			pos_q <= pos_q + step_ext;
		end
	end

	// Segment endpoints from the kind and the current position
	always_comb begin
		sx    = '0;
		sy    = '0;
		sz    = '0;
		ex    = '0;
		ey    = '0;
		ez    = '0;
		color = gal_pkg::ColorGray;
		last  = 1'b0;
		case (cmd.seg)
			gal_pkg::SEG_COL: begin
				sx = pos_q;     sz = -height_q;
				ex = pos_q;     ez = height_q;
			end
			gal_pkg::SEG_COL_POS: begin
				sx = pos_q;
				ex = pos_q;     ez = height_q;
				color = gal_pkg::ColorBlue;
			end
			gal_pkg::SEG_COL_NEG: begin
				sx = pos_q;     sz = -height_q;
				ex = pos_q;
			end
			gal_pkg::SEG_ROW: begin
				sx = -width_q;  sz = pos_q;
				ex = width_q;   ez = pos_q;
			end
			gal_pkg::SEG_ROW_POS: begin
				sz = pos_q;
				ex = width_q;   ez = pos_q;
				color = gal_pkg::ColorRed;
			end
			gal_pkg::SEG_ROW_NEG: begin
				sx = -width_q;  sz = pos_q;
				ez = pos_q;
			end
			gal_pkg::SEG_YAXIS: begin
				ey = width_q;
				color = gal_pkg::ColorGreen;
			end
			gal_pkg::SEG_TOP: begin
				sx = -width_q;  sz = height_q;
				ex = width_q;   ez = height_q;
				color = gal_pkg::ColorWhite;
			end
			gal_pkg::SEG_BOTTOM: begin
				sx = -width_q;  sz = -height_q;
				ex = width_q;   ez = -height_q;
				color = gal_pkg::ColorWhite;
			end
			gal_pkg::SEG_LEFT: begin
				sx = -width_q;  sz = height_q;
				ex = -width_q;  ez = -height_q;
				color = gal_pkg::ColorWhite;
			end
			gal_pkg::SEG_RIGHT: begin
				sx = width_q;   sz = height_q;
				ex = width_q;   ez = -height_q;
				color = gal_pkg::ColorWhite;
				last = 1'b1;
			end
			default: begin
				color = gal_pkg::ColorGray;
			end
		endcase
	end

	// Output register: drop valid once taken, reload on emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			sx_q    <= sx;
			sy_q    <= sy;
			sz_q    <= sz;
			ex_q    <= ex;
			ey_q    <= ey;
			ez_q    <= ez;
			color_q <= color;
			last_q  <= last;
		end
	end

	assign status.col_count = cols_q;
	assign status.row_count = rows_q;
	assign status.out_free  = !out_valid_q || !out_stall;

	assign out_valid    = out_valid_q;
	assign start_x      = sx_q;
	assign start_y      = sy_q;
	assign start_z      = sz_q;
	assign end_x        = ex_q;
	assign end_y        = ey_q;
	assign end_z        = ez_q;
	assign color_code   = color_q;
	assign last_segment = last_q;

endmodule

// ===== rtl/core/gal_ctrl.sv =====
// Sequencer of the grid axis line generator: walks columns, rows, Y axis and border.
// Depends on gal_pkg and grid_axis_line_generator_defines.svh.
`include "grid_axis_line_generator_defines.svh"

module gal_ctrl #(
	parameter int HALF_MAX = gal_pkg::HalfMaxDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output gal_pkg::dp_cmd_t    cmd,
	input  gal_pkg::dp_status_t status
);

	localparam int CntW = $clog2(2 * HALF_MAX);
	localparam int ExtW = CntW + 1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_PREP_COL,
		ST_COL,
		ST_COL_NEG,
		ST_PREP_ROW,
		ST_ROW,
		ST_ROW_NEG,
		ST_YAXIS,
		ST_TOP,
		ST_BOTTOM,
		ST_LEFT,
		ST_RIGHT
	} state_t;

	state_t          state_q;
	logic [CntW-1:0] idx_q;

	logic [ExtW-1:0] idx_ext;
	logic [ExtW-1:0] cols_ext;
	logic [ExtW-1:0] rows_ext;
	logic [ExtW-1:0] last_col;
	logic [ExtW-1:0] last_row;
	logic            accept;
	logic            free;
	logic            col_walk;
	logic            row_walk;
	logic            right_emit;

	assign idx_ext  = ExtW'(idx_q);
	assign cols_ext = ExtW'(status.col_count);
	assign rows_ext = ExtW'(status.row_count);
	assign last_col = ExtW'({status.col_count, 1'b0}) - ExtW'(1);
	assign last_row = ExtW'({status.row_count, 1'b0}) - ExtW'(1);
	assign free     = status.out_free;
	assign accept   = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);

	assign col_walk   = (state_q == ST_COL) || (state_q == ST_COL_NEG);
	assign row_walk   = (state_q == ST_ROW) || (state_q == ST_ROW_NEG);
	assign right_emit = cmd.emit && (cmd.seg == gal_pkg::SEG_RIGHT);

	always_comb begin
		cmd      = '0;
		cmd.seg  = gal_pkg::SEG_COL;
		cmd.load = accept;
		case (state_q)
			ST_LOAD:     cmd.calc = 1'b1;
			ST_PREP_COL: cmd.pos_col_init = 1'b1;
			ST_PREP_ROW: cmd.pos_row_init = 1'b1;
			ST_COL: begin
				cmd.emit = free;
				if (idx_ext == cols_ext) begin
					cmd.seg = gal_pkg::SEG_COL_POS;
				end else begin
					cmd.seg     = gal_pkg::SEG_COL;
					cmd.pos_adv = free;
				end
			end
			ST_COL_NEG: begin
				cmd.emit    = free;
				cmd.seg     = gal_pkg::SEG_COL_NEG;
				cmd.pos_adv = free;
			end
			ST_ROW: begin
				cmd.emit = free;
				if (idx_ext == rows_ext) begin
					cmd.seg = gal_pkg::SEG_ROW_POS;
				end else begin
					cmd.seg     = gal_pkg::SEG_ROW;
					cmd.pos_adv = free;
				end
			end
			ST_ROW_NEG: begin
				cmd.emit    = free;
				cmd.seg     = gal_pkg::SEG_ROW_NEG;
				cmd.pos_adv = free;
			end
			ST_YAXIS: begin
				cmd.emit = free;
				cmd.seg  = gal_pkg::SEG_YAXIS;
			end
			ST_TOP: begin
				cmd.emit = free;
				cmd.seg  = gal_pkg::SEG_TOP;
			end
			ST_BOTTOM: begin
				cmd.emit = free;
				cmd.seg  = gal_pkg::SEG_BOTTOM;
			end
			ST_LEFT: begin
				cmd.emit = free;
				cmd.seg  = gal_pkg::SEG_LEFT;
			end
			ST_RIGHT: begin
				cmd.emit = free;
				cmd.seg  = gal_pkg::SEG_RIGHT;
			end
			default: cmd.load = accept;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= ST_LOAD;
				end
				ST_LOAD: state_q <= ST_PREP_COL;
				ST_PREP_COL: begin
					idx_q   <= CntW'(1);
					state_q <= (status.col_count == '0) ? ST_PREP_ROW : ST_COL;
				end
				ST_COL: begin
					if (free) begin
						if (idx_ext == cols_ext) begin
							state_q <= ST_COL_NEG;
						end else if (idx_ext == last_col) begin
							state_q <= ST_PREP_ROW;
						end else begin
							idx_q <= idx_q + CntW'(1);
						end
					end
				end
				ST_COL_NEG: begin
					if (free) begin
						if (idx_ext == last_col) begin
							state_q <= ST_PREP_ROW;
						end else begin
							idx_q   <= idx_q + CntW'(1);
							state_q <= ST_COL;
						end
					end
				end
				ST_PREP_ROW: begin
					idx_q   <= CntW'(1);
					state_q <= (status.row_count == '0) ? ST_YAXIS : ST_ROW;
				end
				ST_ROW: begin
					if (free) begin
						if (idx_ext == rows_ext) begin
							state_q <= ST_ROW_NEG;
						end else if (idx_ext == last_row) begin
							state_q <= ST_YAXIS;
						end else begin
							idx_q <= idx_q + CntW'(1);
						end
					end
				end
				ST_ROW_NEG: begin
					if (free) begin
						if (idx_ext == last_row) begin
							state_q <= ST_YAXIS;
						end else begin
							idx_q   <= idx_q + CntW'(1);
							state_q <= ST_ROW;
						end
					end
				end
				ST_YAXIS:  if (free) state_q <= ST_TOP;
				ST_TOP:    if (free) state_q <= ST_BOTTOM;
				ST_BOTTOM: if (free) state_q <= ST_LEFT;
				ST_LEFT:   if (free) state_q <= ST_RIGHT;
				ST_RIGHT:  if (free) state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	`GAL_ASSERT_IMPL(a_emit_has_room, cmd.emit, status.out_free, "segment issued while full")
	`GAL_ASSERT_NEXT(a_right_ends_req, right_emit, state_q == ST_IDLE, "request did not end")
	`GAL_ASSERT_IMPL(a_col_idx, col_walk, (idx_q != '0) && (idx_ext <= last_col), "bad column index")
	`GAL_ASSERT_IMPL(a_row_idx, row_walk, (idx_q != '0) && (idx_ext <= last_row), "bad row index")

endmodule

// ===== rtl/core/grid_axis_line_generator.sv =====
// Throughput: one segment per cycle while out_stall is low; a request of C half columns and R half rows
//   (each saturated to HALF_MAX) yields 2C+2R+5 segments.
// Reset: arst_n low clears the sequencer and the output valid flag; a new request
//   can be taken as soon as reset is released, since the sequencer resets to idle.
module grid_axis_line_generator #(
	parameter int HALF_MAX = gal_pkg::HalfMaxDefault
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Request channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [gal_pkg::CountW-1:0]        half_columns,
	input  logic [gal_pkg::CountW-1:0]        rows_per_side,
	input  logic [gal_pkg::StepW-1:0]         step_size,
	// Segment channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [gal_pkg::CoordW-1:0] start_x,
	output logic signed [gal_pkg::CoordW-1:0] start_y,
	output logic signed [gal_pkg::CoordW-1:0] start_z,
	output logic signed [gal_pkg::CoordW-1:0] end_x,
	output logic signed [gal_pkg::CoordW-1:0] end_y,
	output logic signed [gal_pkg::CoordW-1:0] end_z,
	output logic [gal_pkg::ColorW-1:0]        color_code,
	output logic                              last_segment
);

	// The sequencer takes one request at a time. After capture it forms the
	// half width and half depth (count times step), seeds the column
	// position, then walks the columns from most negative X, splitting the
	// center column into a blue +Z half and a gray -Z half. Rows follow the
	// same way with a red +X half, then the green Y axis and the four white
	// border lines. Positions advance by adding the step, so the only
	// multiplies are the two small extent products.
	//
	// The output register decouples the two sides: a stalled segment holds
	// while the sequencer waits, and the next request is taken while the final
	// segment of the previous one is still waiting to be taken.
	gal_pkg::dp_cmd_t    cmd;
	gal_pkg::dp_status_t status;

	gal_ctrl #(
		.HALF_MAX (HALF_MAX)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.status   (status)
	);

	gal_datapath #(
		.HALF_MAX (HALF_MAX)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.half_columns  (half_columns),
		.rows_per_side (rows_per_side),
		.step_size     (step_size),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.start_x       (start_x),
		.start_y       (start_y),
		.start_z       (start_z),
		.end_x         (end_x),
		.end_y         (end_y),
		.end_z         (end_z),
		.color_code    (color_code),
		.last_segment  (last_segment)
	);

endmodule

// ===== tb/grid_axis_line_generator_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for grid_axis_line_generator: directed and random grid requests.
// Depends on gal_pkg and the generator RTL; expected segments come from an in-bench grid model.
module grid_axis_line_generator_tb;

	localparam int HalfMax    = gal_pkg::HalfMaxDefault;
	localparam int CycleLimit = 400000;
	localparam int RandomRequests = 110;
	localparam int DrainCycles = 40;

	// One line segment as it leaves the segment channel
	typedef struct {
		gal_pkg::coord_t sx;
		gal_pkg::coord_t sy;
		gal_pkg::coord_t sz;
		gal_pkg::coord_t ex;
		gal_pkg::coord_t ey;
		gal_pkg::coord_t ez;
		gal_pkg::color_t color;
		logic            last;
	} grid_segment_t;

	// One directed request; seg_count is the hand-computed segment total, 0 where not typed
	typedef struct {
		logic [gal_pkg::CountW-1:0] hc;
		logic [gal_pkg::CountW-1:0] hr;
		logic [gal_pkg::StepW-1:0]  step;
		int                         seg_count;
	} grid_request_t;

	logic clk = 1'b0;
	logic arst_n;

	logic                       in_valid;
	logic                       in_stall;
	logic [gal_pkg::CountW-1:0] half_columns;
	logic [gal_pkg::CountW-1:0] rows_per_side;
	logic [gal_pkg::StepW-1:0]  step_size;

	logic            out_valid;
	logic            out_stall;
	gal_pkg::coord_t start_x;
	gal_pkg::coord_t start_y;
	gal_pkg::coord_t start_z;
	gal_pkg::coord_t end_x;
	gal_pkg::coord_t end_y;
	gal_pkg::coord_t end_z;
	gal_pkg::color_t color_code;
	logic            last_segment;

	grid_segment_t expected_segments[$];
	int            typed_segment_counts[$];
	int            segs_in_request;
	int            errors;
	int            cycle_count;
	bit            steady_phase;

	grid_request_t directed_rows [20];

	grid_axis_line_generator #(
		.HALF_MAX(HalfMax)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.half_columns (half_columns),
		.rows_per_side(rows_per_side),
		.step_size    (step_size),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.start_x      (start_x),
		.start_y      (start_y),
		.start_z      (start_z),
		.end_x        (end_x),
		.end_y        (end_y),
		.end_z        (end_z),
		.color_code   (color_code),
		.last_segment (last_segment)
	);

	always #5 clk = ~clk;

	// Count every failure; print only the first ten in full
	function automatic void report_error(input string msg);
		errors++;
		if (errors <= 10) begin
			$display("[%0t] ERROR: %s", $realtime, msg);
		end
	endfunction

	// Append one expected segment; coordinates are cut to the port width here
	function automatic void push_segment(input int sx, input int sy, input int sz,
			input int ex, input int ey, input int ez, input gal_pkg::color_t col);
		grid_segment_t seg;
		seg.sx    = gal_pkg::coord_t'(sx);
		seg.sy    = gal_pkg::coord_t'(sy);
		seg.sz    = gal_pkg::coord_t'(sz);
		seg.ex    = gal_pkg::coord_t'(ex);
		seg.ey    = gal_pkg::coord_t'(ey);
		seg.ez    = gal_pkg::coord_t'(ez);
		seg.color = col;
		seg.last  = 1'b0;
		expected_segments.push_back(seg);
	endfunction

	// Work out every segment of one grid request, in emission order
	function automatic void predict_grid(input logic [gal_pkg::CountW-1:0] hc_in,
			input logic [gal_pkg::CountW-1:0] hr_in, input logic [gal_pkg::StepW-1:0] step_in);
		int c;
		int r;
		int s;
		int w;
		int h;
		int pos;
		// Saturate oversized half counts
		c = (int'(hc_in) > HalfMax) ? HalfMax : int'(hc_in);
		r = (int'(hr_in) > HalfMax) ? HalfMax : int'(hr_in);
		s = int'(step_in);
		w = c * s;
		h = r * s;
		// Columns, most negative X first; the center one splits into blue +Z and gray -Z
		for (int i = 1; i < 2 * c; i++) begin
			pos = (i - c) * s;
			if (i != c) begin
				push_segment(pos, 0, -h, pos, 0, h, gal_pkg::ColorGray);
			end else begin
				push_segment(pos, 0, 0, pos, 0, h, gal_pkg::ColorBlue);
				push_segment(pos, 0, -h, pos, 0, 0, gal_pkg::ColorGray);
			end
		end
		// Rows, most negative Z first; the center one splits into red +X and gray -X
		for (int j = 1; j < 2 * r; j++) begin
			pos = (j - r) * s;
			if (j != r) begin
				push_segment(-w, 0, pos, w, 0, pos, gal_pkg::ColorGray);
			end else begin
				push_segment(0, 0, pos, w, 0, pos, gal_pkg::ColorRed);
				push_segment(-w, 0, pos, 0, 0, pos, gal_pkg::ColorGray);
			end
		end
		// Y axis height follows the half width, not the half depth
		push_segment(0, 0, 0, 0, w, 0, gal_pkg::ColorGreen);
		// Border: far edge, near edge, left edge, right edge
		push_segment(-w, 0, h, w, 0, h, gal_pkg::ColorWhite);
		push_segment(-w, 0, -h, w, 0, -h, gal_pkg::ColorWhite);
		push_segment(-w, 0, h, -w, 0, -h, gal_pkg::ColorWhite);
		push_segment(w, 0, h, w, 0, -h, gal_pkg::ColorWhite);
		expected_segments[expected_segments.size() - 1].last = 1'b1;
	endfunction

	// Offer one request, idling first at random; call at a rising edge
	task automatic send_request(input logic [gal_pkg::CountW-1:0] hc,
			input logic [gal_pkg::CountW-1:0] hr, input logic [gal_pkg::StepW-1:0] st,
			input int seg_count);
		if (!steady_phase && $urandom_range(0, 99) < 32) begin
			// Drop valid for a random gap
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < 32) @(posedge clk);
		end
		in_valid      <= 1'b1;
		half_columns  <= hc;
		rows_per_side <= hr;
		step_size     <= st;
		// Hold the request until the block takes it
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_grid(hc, hr, st);
		typed_segment_counts.push_back(seg_count);
	endtask

	// Receiver: check each accepted segment, then pick the next stall at random outside the steady phase
	always @(posedge clk) begin
		grid_segment_t want;
		string         bad;
		int            typed;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_segments.size() == 0) begin
				report_error($sformatf("unexpected segment (%0d,%0d,%0d)-(%0d,%0d,%0d) color %0d",
					start_x, start_y, start_z, end_x, end_y, end_z, color_code));
			end else begin
				want = expected_segments.pop_front();
				bad  = "";
				if (start_x !== want.sx) bad = {bad, " start_x"};
				if (start_y !== want.sy) bad = {bad, " start_y"};
				if (start_z !== want.sz) bad = {bad, " start_z"};
				if (end_x !== want.ex) bad = {bad, " end_x"};
				if (end_y !== want.ey) bad = {bad, " end_y"};
				if (end_z !== want.ez) bad = {bad, " end_z"};
				if (color_code !== want.color) bad = {bad, " color_code"};
				if (last_segment !== want.last) bad = {bad, " last_segment"};
				if (bad != "") begin
					report_error($sformatf({"mismatch in%s: expected (%0d,%0d,%0d)-(%0d,%0d,%0d)",
						" color %0d last %0b, got (%0d,%0d,%0d)-(%0d,%0d,%0d) color %0d last %0b"},
						bad, want.sx, want.sy, want.sz, want.ex, want.ey, want.ez,
						want.color, want.last, start_x, start_y, start_z, end_x, end_y, end_z,
						color_code, last_segment));
				end
			end
			segs_in_request++;
			// Close out the request and compare with its hand-computed total, if any
			if (last_segment === 1'b1) begin
				if (typed_segment_counts.size() != 0) begin
					typed = typed_segment_counts.pop_front();
					if (typed != 0 && typed != segs_in_request) begin
						report_error($sformatf("request gave %0d segments, expected %0d",
							segs_in_request, typed));
					end
				end
				segs_in_request = 0;
			end
		end
		if (!arst_n || steady_phase) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(0, 99) < 32);
		end
	end

	// Watchdog: end a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		logic [gal_pkg::CountW-1:0] rand_hc;
		logic [gal_pkg::CountW-1:0] rand_hr;
		logic [gal_pkg::StepW-1:0]  rand_step;

		// Directed rows: zero counts, lone center lines, saturation, zero and full steps
		directed_rows = '{
			'{4'd0,  4'd0,  16'h0000, 5},
			'{4'd0,  4'd0,  16'hFFFF, 5},
			'{4'd1,  4'd0,  16'h0100, 7},
			'{4'd0,  4'd1,  16'h0100, 7},
			'{4'd1,  4'd1,  16'h0100, 9},
			'{4'd14, 4'd14, 16'hFFFF, 61},
			'{4'd15, 4'd15, 16'hFFFF, 61},
			'{4'd15, 4'd0,  16'h0001, 33},
			'{4'd0,  4'd15, 16'h0001, 33},
			'{4'd5,  4'd3,  16'h0000, 21},
			'{4'd15, 4'd15, 16'h0000, 61},
			'{4'd2,  4'd3,  16'h8000, 0},
			'{4'd7,  4'd7,  16'hFFFF, 0},
			'{4'd3,  4'd2,  16'h0001, 0},
			'{4'd10, 4'd4,  16'h00FF, 0},
			'{4'd4,  4'd10, 16'hFF00, 0},
			'{4'd8,  4'd1,  16'h5555, 0},
			'{4'd1,  4'd8,  16'hAAAA, 0},
			'{4'd13, 4'd12, 16'h7FFF, 0},
			'{4'd14, 4'd1,  16'hFFFE, 0}
		};

		arst_n          = 1'b0;
		in_valid        = 1'b0;
		half_columns    = '0;
		rows_per_side   = '0;
		step_size       = '0;
		out_stall       = 1'b0;
		errors          = 0;
		cycle_count     = 0;
		segs_in_request = 0;
		steady_phase    = 1'b0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[k]) begin
			send_request(directed_rows[k].hc, directed_rows[k].hr, directed_rows[k].step,
				directed_rows[k].seg_count);
		end

		for (int n = 0; n < RandomRequests; n++) begin
			// Run a stretch of requests with neither side idling
			steady_phase = (n >= 50 && n < 85);
			// Favor the edges of the count range, including the saturating code
			case ($urandom_range(0, 4))
				0: rand_hc = 4'd0;
				1: rand_hc = 4'($urandom_range(14, 15));
				default: rand_hc = 4'($urandom_range(0, 15));
			endcase
			case ($urandom_range(0, 4))
				0: rand_hr = 4'd0;
				1: rand_hr = 4'($urandom_range(14, 15));
				default: rand_hr = 4'($urandom_range(0, 15));
			endcase
			case ($urandom_range(0, 7))
				0: rand_step = 16'h0000;
				1: rand_step = 16'hFFFF;
				2: rand_step = 16'($urandom_range(1, 1023));
				default: rand_step = 16'($urandom);
			endcase
			send_request(rand_hc, rand_hr, rand_step, 0);
		end
		steady_phase = 1'b0;
		in_valid <= 1'b0;

		// Drain outstanding segments, then give stray ones a chance to show up
		while (expected_segments.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (errors == 0 && expected_segments.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ===== grid_axis_line_generator.f =====
+incdir+rtl/core
rtl/core/gal_pkg.sv
rtl/core/gal_datapath.sv
rtl/core/gal_ctrl.sv
rtl/core/grid_axis_line_generator.sv
tb/grid_axis_line_generator_tb.sv
